[sv/kuf_pkg.sv]
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants of the union-find edge filter: request and
// result payloads, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package kuf_pkg;

  localparam int NUM_VERTICES_DEF = 1024;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VERTEX_BITS = 10;
  localparam int WEIGHT_W    = 16;
  localparam int COUNT_BITS  = 10;
  localparam int RANK_BITS   = 4;

  localparam logic [RANK_BITS-1:0] RANK_MAX = 4'd15;

  typedef struct packed {
    logic                   new_graph;
    logic [WEIGHT_W-1:0]    edge_weight;
    logic [VERTEX_BITS-1:0] vertex_u;
    logic [VERTEX_BITS-1:0] vertex_v;
  } kuf_edge_t;

  typedef struct packed {
    logic                   accepted;
    logic [WEIGHT_W-1:0]    out_weight;
    logic [VERTEX_BITS-1:0] out_u;
    logic [VERTEX_BITS-1:0] out_v;
    logic [COUNT_BITS-1:0]  tree_edges;
  } kuf_result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_FIND_A,
    ST_FIND_B,
    ST_COMP_B,
    ST_RANK_U,
    ST_RANK_V,
    ST_UNION,
    ST_FINISH
  } kuf_state_e;

endpackage

[sv/kuf_stream_if.sv]
// ----------------------------------------------------------------------------
// kuf_stream_if
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface kuf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/kruskal_union_find_edge_filter.sv]
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Kruskal edge filter over a disjoint-set forest with union by rank and full
// path compression.
// ----------------------------------------------------------------------------
// Usage: edges enter on edge_i (valid/ready), already sorted by weight. Each
// edge gives one result on result_o: accepted flag, the edge echoed back, and
// the running count of tree edges in the current graph.
// An edge is taken only while the sequencer is idle; a finished result sits
// in the output register, so the next edge is taken while it waits.
// Lookup time grows with the depths du and dv of the endpoints in the forest
// (at most log2 of NUM_VERTICES); an accepted edge also passes through the
// rank reads and the union write, and an edge with an endpoint out of range
// goes straight to its result. The sequencer returns to idle, ready for the
// next edge, as the result is loaded into the output register.
// Every hop is one read of the parent memory, and each compression step one
// read plus one write-back in the same cycle.
// Reset and a request with new_graph set start a sweep over the parent and
// rank memories; no edge is taken during the sweep after reset, and an edge
// with new_graph waits for it before its endpoints are looked up.
// When the receiver stalls, the finished result holds in the output register
// and the sequencer waits in its last state until the register frees.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter #(
  parameter int NUM_VERTICES = kuf_pkg::NUM_VERTICES_DEF,
  parameter int WEIGHT_BITS  = kuf_pkg::WEIGHT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kuf_stream_if.sink   edge_i,
  kuf_stream_if.source result_o
);
  import kuf_pkg::*;

  localparam int AW = $clog2(NUM_VERTICES);
  localparam int WB = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam logic [WEIGHT_W-1:0] W_MASK = WEIGHT_W'((33'd1 << WB) - 33'd1);

  kuf_state_e            state_q, state_d;
  kuf_edge_t             item_q, item_d;
  logic                  pending_q, pending_d;
  logic                  side_q, side_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         start_q, start_d;
  logic [AW-1:0]         root_q, root_d;
  logic [AW-1:0]         ru_q, ru_d;
  logic [AW-1:0]         rv_q, rv_d;
  logic [RANK_BITS-1:0]  rank_u_q, rank_u_d;
  logic                  acc_q, acc_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  kuf_result_t           out_q, out_d;

  logic                  ram_clear;
  logic                  ram_busy;
  logic [AW-1:0]         par_rd_addr;
  logic [AW-1:0]         par_rd_data;
  logic                  par_we;
  logic [AW-1:0]         par_wr_addr;
  logic [AW-1:0]         par_wr_data;
  logic [AW-1:0]         rank_rd_addr;
  logic [RANK_BITS-1:0]  rank_rd_data;
  logic                  rank_we;
  logic [AW-1:0]         rank_wr_addr;
  logic [RANK_BITS-1:0]  rank_wr_data;
  logic                  in_range;
  logic                  ep_done;
  logic [AW-1:0]         ep_root;

  kuf_forest_ram #(
    .NUM_VERTICES (NUM_VERTICES),
    .AW           (AW)
  ) u_ram (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (ram_clear),
    .busy_o         (ram_busy),
    .par_rd_addr_i  (par_rd_addr),
    .par_rd_data_o  (par_rd_data),
    .par_we_i       (par_we),
    .par_wr_addr_i  (par_wr_addr),
    .par_wr_data_i  (par_wr_data),
    .rank_rd_addr_i (rank_rd_addr),
    .rank_rd_data_o (rank_rd_data),
    .rank_we_i      (rank_we),
    .rank_wr_addr_i (rank_wr_addr),
    .rank_wr_data_i (rank_wr_data)
  );

  assign in_range = (32'(item_q.vertex_u) < NUM_VERTICES) &&
                    (32'(item_q.vertex_v) < NUM_VERTICES);

  assign edge_i.ready    = (state_q == ST_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_q;

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    pending_d    = pending_q;
    side_d       = side_q;
    cur_d        = cur_q;
    start_d      = start_q;
    root_d       = root_q;
    ru_d         = ru_q;
    rv_d         = rv_q;
    rank_u_d     = rank_u_q;
    acc_d        = acc_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ram_clear    = 1'b0;
    par_rd_addr  = cur_q;
    par_we       = 1'b0;
    par_wr_addr  = cur_q;
    par_wr_data  = root_q;
    rank_rd_addr = ru_q;
    rank_we      = 1'b0;
    rank_wr_addr = ru_q;
    rank_wr_data = rank_u_q + RANK_BITS'(1);
    ep_done      = 1'b0;
    ep_root      = cur_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        if (!ram_busy) begin
          state_d   = pending_q ? ST_START : ST_IDLE;
          pending_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (edge_i.valid) begin
          item_d = edge_i.data;
          if (edge_i.data.new_graph) begin
            ram_clear = 1'b1;
            count_d   = '0;
            pending_d = 1'b1;
            state_d   = ST_CLEAR;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        acc_d = 1'b0;
        if (in_range) begin
          side_d  = 1'b0;
          cur_d   = AW'(item_q.vertex_u);
          start_d = AW'(item_q.vertex_u);
          state_d = ST_FIND_A;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FIND_A: begin
        state_d = ST_FIND_B;
      end
      ST_FIND_B: begin
        if (par_rd_data != cur_q) begin
          cur_d       = par_rd_data;
          par_rd_addr = par_rd_data;
        end else if (start_q == cur_q) begin
          ep_done = 1'b1;
          ep_root = cur_q;
        end else begin
          root_d      = cur_q;
          cur_d       = start_q;
          par_rd_addr = start_q;
          state_d     = ST_COMP_B;
        end
      end
      ST_COMP_B: begin
        // repoint this vertex at the root, then follow its old parent
        par_we = 1'b1;
        if (par_rd_data == root_q) begin
          ep_done = 1'b1;
          ep_root = root_q;
        end else begin
          cur_d       = par_rd_data;
          par_rd_addr = par_rd_data;
        end
      end
      ST_RANK_U: begin
        rank_rd_addr = ru_q;
        state_d      = ST_RANK_V;
      end
      ST_RANK_V: begin
        rank_u_d     = rank_rd_data;
        rank_rd_addr = rv_q;
        state_d      = ST_UNION;
      end
      ST_UNION: begin
        par_we = 1'b1;
        if (rank_u_q >= rank_rd_data) begin
          par_wr_addr = rv_q;
          par_wr_data = ru_q;
          if ((rank_u_q == rank_rd_data) && (rank_u_q != RANK_MAX)) begin
            rank_we = 1'b1;
          end
        end else begin
          par_wr_addr = ru_q;
          par_wr_data = rv_q;
        end
        acc_d   = 1'b1;
        count_d = count_q + COUNT_BITS'(1);
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d      = 1'b1;
          out_d.accepted   = acc_q;
          out_d.out_weight = item_q.edge_weight & W_MASK;
          out_d.out_u      = item_q.vertex_u;
          out_d.out_v      = item_q.vertex_v;
          out_d.tree_edges = count_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ep_done) begin
      if (!side_q) begin
        ru_d    = ep_root;
        side_d  = 1'b1;
        cur_d   = AW'(item_q.vertex_v);
        start_d = AW'(item_q.vertex_v);
        state_d = ST_FIND_A;
      end else begin
        rv_d    = ep_root;
        state_d = (ep_root == ru_q) ? ST_FINISH : ST_RANK_U;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pending_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    side_q   <= side_d;
    cur_q    <= cur_d;
    start_q  <= start_d;
    root_q   <= root_d;
    ru_q     <= ru_d;
    rv_q     <= rv_d;
    rank_u_q <= rank_u_d;
    acc_q    <= acc_d;
    out_q    <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_union_distinct_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNION) |-> (ru_q != rv_q))
    else $error("union of a root with itself");

  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_busy |-> (!par_we && !rank_we))
    else $error("forest write during clearing sweep");

  a_compress_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_COMP_B) && (state_d == ST_COMP_B)) |-> (cur_d != cur_q))
    else $error("compression walk reads the entry it writes");

  a_finish_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && (state_d == ST_IDLE)) |=> out_valid_q)
    else $error("finished result not presented");

  a_new_graph_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_i.valid && edge_i.ready && edge_i.data.new_graph) |=>
      ((count_q == '0) && (state_q == ST_CLEAR)))
    else $error("new graph did not clear the tree count");
`endif

endmodule

[sv/kuf_forest_ram.sv]
// ----------------------------------------------------------------------------
// kuf_forest_ram
// Parent and rank memories of the disjoint-set forest, with registered reads,
// and a sweep that makes every vertex a singleton after reset or on request.
// ----------------------------------------------------------------------------
module kuf_forest_ram #(
  parameter int NUM_VERTICES = kuf_pkg::NUM_VERTICES_DEF,
  parameter int AW           = $clog2(NUM_VERTICES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  output logic                         busy_o,
  input  logic [AW-1:0]                par_rd_addr_i,
  output logic [AW-1:0]                par_rd_data_o,
  input  logic                         par_we_i,
  input  logic [AW-1:0]                par_wr_addr_i,
  input  logic [AW-1:0]                par_wr_data_i,
  input  logic [AW-1:0]                rank_rd_addr_i,
  output logic [kuf_pkg::RANK_BITS-1:0] rank_rd_data_o,
  input  logic                         rank_we_i,
  input  logic [AW-1:0]                rank_wr_addr_i,
  input  logic [kuf_pkg::RANK_BITS-1:0] rank_wr_data_i
);
  import kuf_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_VERTICES - 1);

  logic [AW-1:0]        parent_mem [NUM_VERTICES];
  logic [RANK_BITS-1:0] rank_mem   [NUM_VERTICES];

  logic                 busy_q, busy_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic [AW-1:0]        par_rd_q;
  logic [RANK_BITS-1:0] rank_rd_q;

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (clear_i) begin
      busy_d     = 1'b1;
      clr_addr_d = '0;
    end else if (busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      parent_mem[clr_addr_q] <= clr_addr_q;
    end else if (par_we_i) begin
      parent_mem[par_wr_addr_i] <= par_wr_data_i;
    end
    par_rd_q <= parent_mem[par_rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rank_mem[clr_addr_q] <= '0;
    end else if (rank_we_i) begin
      rank_mem[rank_wr_addr_i] <= rank_wr_data_i;
    end
    rank_rd_q <= rank_mem[rank_rd_addr_i];
  end

  assign busy_o         = busy_q;
  assign par_rd_data_o  = par_rd_q;
  assign rank_rd_data_o = rank_rd_q;

endmodule
